FILE: rtl/core/agl1_pkg.sv
package agl1_pkg;

  localparam int IDX_W    = 10;
  localparam int DIM      = 1 << IDX_W;
  localparam int DATA_W   = 32;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int DEN_W    = 33;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int ACC_W    = SUM_W + 3;
  localparam int CLR_W    = $clog2(DIM + 1);
  localparam int PADDR_W  = 4;

  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_L1_STRENGTH   = 2'd1;
  localparam logic [1:0] REG_DELTA_OFFSET  = 2'd2;

  localparam logic [DATA_W-1:0] LEARNING_RATE_RST = 32'd65536;
  localparam logic [DATA_W-1:0] L1_STRENGTH_RST   = 32'd655;
  localparam logic [DATA_W-1:0] DELTA_OFFSET_RST  = 32'd65536;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             gneg;
    logic [SUM_W-1:0] num_step;
    logic [SUM_W-1:0] num_thr;
  } sq_side_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             gneg;
  } dv_side_t;

endpackage

FILE: rtl/core/adagrad_l1_weight_update_core.sv
// AdaGrad weight update with L1 soft thresholding over 1024 weights. The block takes one
// gradient word per cycle while in_stall is low and returns one updated weight word per
// input, in order; between them lie a 32-stage square root pipeline and a 64-stage dual
// divider. Updates to the same index may follow each other in consecutive cycles. After
// reset the block clears both state memories, one entry per cycle, and holds in_stall high
// until all 1024 entries are cleared. A stall on a valid output freezes the whole pipeline.
module adagrad_l1_weight_update_core import agl1_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         elem_index,
  input  logic signed [DATA_W-1:0] gradient,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] new_weight
);

  logic [DATA_W-1:0] learning_rate;
  logic [DATA_W-1:0] l1_strength;
  logic [DATA_W-1:0] delta_offset;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LEARNING_RATE_RST;
      l1_strength   <= L1_STRENGTH_RST;
      delta_offset  <= DELTA_OFFSET_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LEARNING_RATE: learning_rate <= pwdata;
        REG_L1_STRENGTH:   l1_strength   <= pwdata;
        REG_DELTA_OFFSET:  delta_offset  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEARNING_RATE: prdata = learning_rate;
      REG_L1_STRENGTH:   prdata = l1_strength;
      REG_DELTA_OFFSET:  prdata = delta_offset;
      default:           prdata = '0;
    endcase
  end

  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;

  assign clearing = (clr_cnt != CLR_W'(DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic adv;
  logic accept;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = clearing || !adv;
  assign accept   = in_valid && !in_stall;

  logic              gneg;
  logic [DATA_W-1:0] gbits;
  logic [DATA_W-1:0] gmag;

  assign gbits = gradient;
  assign gneg  = gbits[DATA_W-1];
  assign gmag  = gneg ? (~gbits + 1'b1) : gbits;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_gneg;
  logic [SUM_W-1:0] s1_sq;
  logic [SUM_W-1:0] s1_nstep;
  logic [SUM_W-1:0] s1_nthr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx   <= elem_index;
      s1_gneg  <= gneg;
      s1_sq    <= SUM_W'(gmag) * SUM_W'(gmag);
      s1_nstep <= SUM_W'(learning_rate) * SUM_W'(gmag);
      s1_nthr  <= SUM_W'(l1_strength) * SUM_W'(learning_rate);
    end
  end

  logic [SUM_W-1:0] sum_mem [DIM];
  logic [SUM_W-1:0] sum_rd;
  logic             sum_we;
  logic [IDX_W-1:0] sum_wa;
  logic [SUM_W-1:0] sum_wd;

  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum;
  sq_side_t         s2_side;
  logic [SUM_W-1:0] sum_old;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;

  assign sum_old = (s2_valid && s2_side.idx == s1_idx) ? s2_sum : sum_rd;
  assign sum_add = {1'b0, sum_old} + {1'b0, s1_sq};
  assign sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  assign sum_we = clearing || (adv && s1_valid);
  assign sum_wa = clearing ? clr_cnt[IDX_W-1:0] : s1_idx;
  assign sum_wd = clearing ? '0 : sum_new;

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (adv) begin
      sum_rd <= sum_mem[elem_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum  <= sum_new;
      s2_side <= '{idx: s1_idx, gneg: s1_gneg, num_step: s1_nstep, num_thr: s1_nthr};
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  agl1_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid),
    .x         (s2_sum),
    .side_in   (s2_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  logic             dn_valid;
  logic [DEN_W-1:0] dn_den;
  logic [SUM_W-1:0] dn_nstep;
  logic [SUM_W-1:0] dn_nthr;
  dv_side_t         dn_side;
  logic [DEN_W-1:0] den_sum;

  assign den_sum = {1'b0, delta_offset} + {1'b0, sq_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_den   <= (den_sum == '0) ? DEN_W'(1) : den_sum;
      dn_nstep <= sq_side.num_step;
      dn_nthr  <= sq_side.num_thr;
      dn_side  <= '{idx: sq_side.idx, gneg: sq_side.gneg};
    end
  end

  logic             dv_valid;
  logic [SUM_W-1:0] q_step;
  logic [SUM_W-1:0] q_thr;
  dv_side_t         dv_side;

  agl1_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dn_valid),
    .den       (dn_den),
    .num_a     (dn_nstep),
    .num_b     (dn_nthr),
    .side_in   (dn_side),
    .out_valid (dv_valid),
    .quo_a     (q_step),
    .quo_b     (q_thr),
    .side_out  (dv_side)
  );

  // With v = w + a, where a is the negated signed step, keep a - thr and a + thr so that the
  // last stage needs only one add per branch.
  logic [ACC_W-1:0] x_step;
  logic [ACC_W-1:0] x_thr;
  logic [ACC_W-1:0] x_sel;
  logic [ACC_W-1:0] am_next;
  logic [ACC_W-1:0] ap_next;

  assign x_step  = ACC_W'(q_step);
  assign x_thr   = ACC_W'(q_thr);
  assign x_sel   = dv_side.gneg ? x_step : ~x_step;
  assign am_next = x_sel + ~x_thr + (dv_side.gneg ? ACC_W'(1) : ACC_W'(2));
  assign ap_next = x_sel + x_thr + (dv_side.gneg ? ACC_W'(0) : ACC_W'(1));

  logic             pr_valid;
  logic [IDX_W-1:0] pr_idx;
  logic [ACC_W-1:0] pr_am;
  logic [ACC_W-1:0] pr_ap;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (adv) begin
      pr_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_idx <= dv_side.idx;
      pr_am  <= am_next;
      pr_ap  <= ap_next;
    end
  end

  logic [DATA_W-1:0] w_mem [DIM];
  logic [DATA_W-1:0] w_rd;
  logic              w_we;
  logic [IDX_W-1:0]  w_wa;
  logic [DATA_W-1:0] w_wd;

  logic              f_valid;
  logic [IDX_W-1:0]  f_idx;
  logic [ACC_W-1:0]  f_am;
  logic [ACC_W-1:0]  f_ap;
  logic [DATA_W-1:0] w_cur;
  logic [ACC_W-1:0]  w_ext;
  logic [ACC_W-1:0]  p_sum;
  logic [ACC_W-1:0]  n_sum;
  logic [DATA_W-1:0] f_weight;

  assign w_cur = (out_valid && out_index == f_idx) ? new_weight : w_rd;
  assign w_ext = {{(ACC_W-DATA_W){w_cur[DATA_W-1]}}, w_cur};
  assign p_sum = w_ext + f_am;
  assign n_sum = w_ext + f_ap;

  always_comb begin
    if (!p_sum[ACC_W-1] && p_sum != '0) begin
      if (p_sum[ACC_W-1:DATA_W-1] != '0) begin
        f_weight = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        f_weight = p_sum[DATA_W-1:0];
      end
    end else if (n_sum[ACC_W-1]) begin
      if (n_sum[ACC_W-1:DATA_W-1] != '1) begin
        f_weight = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        f_weight = n_sum[DATA_W-1:0];
      end
    end else begin
      f_weight = '0;
    end
  end

  assign w_we = clearing || (adv && f_valid);
  assign w_wa = clearing ? clr_cnt[IDX_W-1:0] : f_idx;
  assign w_wd = clearing ? '0 : f_weight;

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    if (adv) begin
      w_rd <= w_mem[pr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      f_valid   <= pr_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_idx      <= pr_idx;
      f_am       <= pr_am;
      f_ap       <= pr_ap;
      out_index  <= f_idx;
      new_weight <= f_weight;
    end
  end

endmodule

FILE: rtl/core/agl1_sqrt.sv
module agl1_sqrt import agl1_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  x,
  input  sq_side_t          side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output sq_side_t          side_out
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [SUM_W-1:0]    x;
  } sq_data_t;

  function automatic sq_data_t sq_step(input sq_data_t d);
    logic [SQ_REM_W+1:0] r;
    logic [SQ_REM_W+1:0] trial;
    sq_data_t            o;
    r     = {d.rem, d.x[SUM_W-1 -: 2]};
    trial = {{(SQ_REM_W-ROOT_W){1'b0}}, d.root, 2'b01};
    o.x   = {d.x[SUM_W-3:0], 2'b00};
    if (r >= trial) begin
      r      = r - trial;
      o.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.root = {d.root[ROOT_W-2:0], 1'b0};
    end
    o.rem = r[SQ_REM_W-1:0];
    return o;
  endfunction

  logic     st_valid [1:ROOT_W];
  sq_data_t st_data  [1:ROOT_W];
  sq_side_t st_side  [1:ROOT_W];

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    logic     pv;
    sq_data_t pd;
    sq_side_t ps;
    if (k == 1) begin : g_first
      assign pv = in_valid;
      assign pd = '{rem: '0, root: '0, x: x};
      assign ps = side_in;
    end else begin : g_next
      assign pv = st_valid[k-1];
      assign pd = st_data[k-1];
      assign ps = st_side[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_data[k] <= sq_step(pd);
        st_side[k] <= ps;
      end
    end
  end

  assign out_valid = st_valid[ROOT_W];
  assign root      = st_data[ROOT_W].root;
  assign side_out  = st_side[ROOT_W];

endmodule

FILE: rtl/core/agl1_div.sv
module agl1_div import agl1_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] den,
  input  logic [SUM_W-1:0] num_a,
  input  logic [SUM_W-1:0] num_b,
  input  dv_side_t         side_in,
  output logic             out_valid,
  output logic [SUM_W-1:0] quo_a,
  output logic [SUM_W-1:0] quo_b,
  output dv_side_t         side_out
);

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem_a;
    logic [DEN_W-1:0] rem_b;
    logic [SUM_W-1:0] nq_a;
    logic [SUM_W-1:0] nq_b;
  } dv_data_t;

  function automatic dv_data_t dv_step(input dv_data_t d);
    logic [DEN_W:0] ra;
    logic [DEN_W:0] rb;
    logic [DEN_W:0] dx;
    logic           ga;
    logic           gb;
    dv_data_t       o;
    dx = {1'b0, d.den};
    ra = {d.rem_a, d.nq_a[SUM_W-1]};
    rb = {d.rem_b, d.nq_b[SUM_W-1]};
    ga = (ra >= dx);
    gb = (rb >= dx);
    if (ga) begin
      ra = ra - dx;
    end
    if (gb) begin
      rb = rb - dx;
    end
    o.den   = d.den;
    o.rem_a = ra[DEN_W-1:0];
    o.rem_b = rb[DEN_W-1:0];
    o.nq_a  = {d.nq_a[SUM_W-2:0], ga};
    o.nq_b  = {d.nq_b[SUM_W-2:0], gb};
    return o;
  endfunction

  logic     st_valid [1:SUM_W];
  dv_data_t st_data  [1:SUM_W];
  dv_side_t st_side  [1:SUM_W];

  for (genvar k = 1; k <= SUM_W; k++) begin : g_stage
    logic     pv;
    dv_data_t pd;
    dv_side_t ps;
    if (k == 1) begin : g_first
      assign pv = in_valid;
      assign pd = '{den: den, rem_a: '0, rem_b: '0, nq_a: num_a, nq_b: num_b};
      assign ps = side_in;
    end else begin : g_next
      assign pv = st_valid[k-1];
      assign pd = st_data[k-1];
      assign ps = st_side[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_data[k] <= dv_step(pd);
        st_side[k] <= ps;
      end
    end
  end

  assign out_valid = st_valid[SUM_W];
  assign quo_a     = st_data[SUM_W].nq_a;
  assign quo_b     = st_data[SUM_W].nq_b;
  assign side_out  = st_side[SUM_W];

endmodule

FILE: test/adagrad_l1_weight_update_core_tb.sv
`timescale 1ns / 100ps

module adagrad_l1_weight_update_core_tb;
  import agl1_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [IDX_W-1:0]         elem_index = '0;
  logic signed [DATA_W-1:0] gradient = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] new_weight;

  adagrad_l1_weight_update_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .elem_index(elem_index), .gradient(gradient),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .new_weight(new_weight)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] weight;
  } weight_word_t;

  logic [DATA_W-1:0]        eta_q;
  logic [DATA_W-1:0]        lambda_q;
  logic [DATA_W-1:0]        delta_q;
  logic signed [DATA_W-1:0] weight_mem [DIM];
  longint unsigned          sq_sum_mem [DIM];
  weight_word_t             pending_weights [$];

  int  mismatches = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;
  int  idx_span = 1024;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, root, bitv;
    rem = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [DATA_W-1:0] update_weight(logic [IDX_W-1:0] idx,
                                                              logic signed [DATA_W-1:0] g);
    longint unsigned gmag, wmag, smag, vmag, sq, sum, den, thr, shrunk;
    bit gneg, wneg, sneg, vneg;
    logic signed [DATA_W-1:0] nw;
    gneg = g[DATA_W-1];
    gmag = gneg ? (64'h1_0000_0000 - {32'd0, g}) : {32'd0, g};
    sq = gmag * gmag;
    sum = sq_sum_mem[idx] + sq;
    if (sum < sq) sum = 64'hFFFF_FFFF_FFFF_FFFF;
    sq_sum_mem[idx] = sum;
    den = {32'd0, delta_q} + int_sqrt(sum);
    if (den == 0) den = 1;
    smag = ({32'd0, eta_q} * gmag) / den;
    thr = ({32'd0, lambda_q} * {32'd0, eta_q}) / den;
    wneg = weight_mem[idx][DATA_W-1];
    wmag = wneg ? (64'h1_0000_0000 - {32'd0, weight_mem[idx]}) : {32'd0, weight_mem[idx]};
    sneg = !gneg && smag != 0;
    if (wneg == sneg) begin
      vneg = wneg;
      vmag = wmag + smag;
    end else if (wmag >= smag) begin
      vneg = wneg;
      vmag = wmag - smag;
    end else begin
      vneg = sneg;
      vmag = smag - wmag;
    end
    if (vmag > thr) begin
      shrunk = vmag - thr;
      if (vneg) nw = (shrunk >= 64'h8000_0000) ? 32'h8000_0000 : DATA_W'(-shrunk);
      else nw = (shrunk > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : DATA_W'(shrunk);
    end else begin
      nw = '0;
    end
    weight_mem[idx] = nw;
    return nw;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] g);
    weight_word_t w;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    elem_index <= idx;
    gradient <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w.idx = idx;
    w.weight = update_weight(idx, g);
    pending_weights.push_back(w);
    words_in++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      4 * REG_LEARNING_RATE: eta_q = value;
      4 * REG_L1_STRENGTH:   lambda_q = value;
      4 * REG_DELTA_OFFSET:  delta_q = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [DATA_W-1:0] eta, logic [DATA_W-1:0] lambda,
                            logic [DATA_W-1:0] delta);
    wait_idle();
    write_reg(4 * REG_LEARNING_RATE, eta);
    write_reg(4 * REG_L1_STRENGTH, lambda);
    write_reg(4 * REG_DELTA_OFFSET, delta);
  endtask

  function automatic logic signed [DATA_W-1:0] random_gradient();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3, 4: return $signed($urandom()) >>> $urandom_range(31);
      default: return $signed($urandom_range(131072)) - 32'sd65536;
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_word(IDX_W'($urandom_range(idx_span - 1)), random_gradient());
  endtask

  task automatic test_directed();
    send_word(10'd0, 32'sd65536);
    send_word(10'd0, -32'sd65536);
    send_word(10'd1023, 32'sh7FFF_FFFF);
    send_word(10'd1023, 32'sh8000_0000);
    repeat (5) send_word(10'd1022, 32'sh8000_0000);
    send_word(10'd5, 32'sd3);
    send_word(10'd5, 32'sd3);
    set_config(32'hFFFF_FFFF, 32'd0, 32'd1);
    send_word(10'd20, 32'sd1);
    send_word(10'd21, -32'sd1);
    send_word(10'd20, 32'sd1);
    send_word(10'd21, -32'sd1);
    send_word(10'd22, 32'sh7FFF_FFFF);
    set_config(32'd65536, 32'd65536, 32'd0);
    send_word(10'd30, 32'sd0);
    send_word(10'd31, 32'sd65536);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(10'd40, 32'sh8000_0000);
    send_word(10'd40, 32'sd123456);
    wait_idle();
    write_reg(4'd12, 32'hDEAD_BEEF);
    send_word(10'd41, 32'sd65536);
  endtask

  task automatic test_config_sweep();
    set_config(LEARNING_RATE_RST, L1_STRENGTH_RST, DELTA_OFFSET_RST);
    idx_span = 64;
    send_random(200);
    set_config(32'd0, $urandom(), $urandom_range(1, 65536));
    send_random(100);
    set_config(32'hFFFF_FFFF, 32'd0, 32'd1);
    send_random(150);
    set_config($urandom_range(1 << 20), $urandom_range(1 << 14), 32'hFFFF_FFFF);
    idx_span = 1024;
    send_random(150);
    set_config($urandom(), $urandom(), $urandom_range(1, 256));
    idx_span = 16;
    send_random(150);
  endtask

  task automatic test_backpressure();
    set_config(32'd131072, 32'd1000, 32'd32768);
    idx_span = 8;
    hold_request = 1'b1;
    no_idle = 1'b1;
    send_random(200);
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    set_config($urandom_range(1 << 18), $urandom_range(1 << 12), $urandom_range(1, 1 << 17));
    idx_span = 32;
    send_random(150);
    no_idle = 1'b1;
    send_random(100);
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      out_stall <= 1'b1;
      repeat (400) @(negedge clk);
      hold_request = 1'b0;
      out_stall <= 1'b0;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(99) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(40, 10)) @(negedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected word, index", out_index, -1);
      end else begin
        weight_word_t w;
        w = pending_weights.pop_front();
        if (out_index !== w.idx) report_mismatch("out_index", out_index, w.idx);
        if (new_weight !== w.weight) report_mismatch("new_weight", new_weight, w.weight);
      end
      words_out++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_weights.size());
      $display("FAIL adagrad_l1_weight_update_core");
      $finish;
    end
  end

  initial begin
    eta_q = LEARNING_RATE_RST;
    lambda_q = L1_STRENGTH_RST;
    delta_q = DELTA_OFFSET_RST;
    for (int i = 0; i < DIM; i++) begin
      weight_mem[i] = '0;
      sq_sum_mem[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_idle();
    $display("Sent %0d gradient words and checked %0d weight words", words_in, words_out);
    $display("over many register settings, saturation, zero denominator and a long output hold.");
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("PASS adagrad_l1_weight_update_core");
    end else begin
      $display("FAIL adagrad_l1_weight_update_core");
    end
    $finish;
  end

endmodule
